// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    localparam int unsigned MaxResults = 5;
    localparam int unsigned CntW       = 3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_N = 8'h6e;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_T = 8'h74;
    localparam logic [7:0] CH_LOW_U = 8'h75;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    typedef enum logic [2:0] {
        PH_OPEN    = 3'd0,
        PH_BODY    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEX_A   = 3'd3,
        PH_WANT_BS = 3'd4,
        PH_WANT_U  = 3'd5,
        PH_HEX_B   = 3'd6,
        PH_IGNORE  = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_BYTE  = 2'd0,
        ST_CLOSE = 2'd1,
        ST_ERR   = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } entry_t;

    typedef struct packed {
        entry_t [MaxResults-1:0] slot;
        logic [CntW-1:0]         cnt;
    } bundle_t;

endpackage

// ===== hw/rtl/jsu_decode.sv =====
// Unescape state machine: decodes one input byte into a bundle of result words.
module jsu_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             advance,
    output jsu_pkg::bundle_t bundle
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [15:0]     acc_reg, acc_next;
    logic [9:0]      hs_reg, hs_next;

    logic [4:0]      hexv;
    logic [15:0]     acc_shift;
    logic [20:0]     cp;
    logic            emit_cp;
    logic            finished;
    logic            closed;
    logic            tail_en;
    logic [2:0]      nb;
    logic [7:0]      ub [4];

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) v = 5'(b - 8'h30);
        else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - 8'h37);
        return v;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jsu_pkg::PH_OPEN;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            hs_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            hs_reg    <= hs_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        finished   = 1'b0;
        closed     = 1'b0;
        emit_cp    = 1'b0;
        cp         = '0;
        nb         = '0;
        tail_en    = 1'b0;
        for (int i = 0; i < 4; i++) ub[i] = '0;
        hexv       = hex_value(in_byte);
        acc_shift  = {acc_reg[11:0], hexv[3:0]};

        unique case (phase_reg)
            jsu_pkg::PH_OPEN:
            begin
                if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    phase_next = jsu_pkg::PH_BODY;
                    cnt_next   = '0;
                    acc_next   = '0;
                    hs_next    = '0;
                end
                else
                    finished = 1'b1;
            end
            jsu_pkg::PH_BODY:
            begin
                if (in_byte == jsu_pkg::CH_QUOTE)
                begin
                    finished = 1'b1;
                    closed   = 1'b1;
                end
                else if (in_byte < jsu_pkg::CH_SPACE)
                    finished = 1'b1;
                else if (in_byte == jsu_pkg::CH_BSLASH)
                    phase_next = jsu_pkg::PH_ESC;
                else
                begin
                    nb    = 3'd1;
                    ub[0] = in_byte;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                phase_next = jsu_pkg::PH_BODY;
                nb         = 3'd1;
                unique case (in_byte)
                    jsu_pkg::CH_QUOTE:  ub[0] = jsu_pkg::CH_QUOTE;
                    jsu_pkg::CH_BSLASH: ub[0] = jsu_pkg::CH_BSLASH;
                    jsu_pkg::CH_SLASH:  ub[0] = jsu_pkg::CH_SLASH;
                    jsu_pkg::CH_LOW_B:  ub[0] = jsu_pkg::CH_BS;
                    jsu_pkg::CH_LOW_F:  ub[0] = jsu_pkg::CH_FF;
                    jsu_pkg::CH_LOW_N:  ub[0] = jsu_pkg::CH_LF;
                    jsu_pkg::CH_LOW_R:  ub[0] = jsu_pkg::CH_CR;
                    jsu_pkg::CH_LOW_T:  ub[0] = jsu_pkg::CH_TAB;
                    jsu_pkg::CH_LOW_U:
                    begin
                        nb         = '0;
                        phase_next = jsu_pkg::PH_HEX_A;
                        cnt_next   = '0;
                        acc_next   = '0;
                    end
                    default:
                    begin
                        nb       = '0;
                        finished = 1'b1;
                    end
                endcase
            end
            jsu_pkg::PH_HEX_A,
            jsu_pkg::PH_HEX_B:
            begin
                if (hexv[4])
                    finished = 1'b1;
                else
                begin
                    acc_next = acc_shift;
                    if (cnt_reg != 2'd3)
                        cnt_next = cnt_reg + 2'd1;
                    else
                    begin
                        cnt_next = '0;
                        if (phase_reg == jsu_pkg::PH_HEX_A)
                        begin
                            if (acc_shift[15:10] == jsu_pkg::HI_SURR_TAG)
                            begin
                                hs_next    = acc_shift[9:0];
                                phase_next = jsu_pkg::PH_WANT_BS;
                            end
                            else if (acc_shift[15:10] == jsu_pkg::LO_SURR_TAG)
                                finished = 1'b1;
                            else
                            begin
                                cp         = {5'd0, acc_shift};
                                emit_cp    = 1'b1;
                                phase_next = jsu_pkg::PH_BODY;
                            end
                        end
                        else if (acc_shift[15:10] != jsu_pkg::LO_SURR_TAG)
                            finished = 1'b1;
                        else
                        begin
                            cp         = 21'h10000 + {1'b0, hs_reg, acc_shift[9:0]};
                            emit_cp    = 1'b1;
                            phase_next = jsu_pkg::PH_BODY;
                        end
                    end
                end
            end
            jsu_pkg::PH_WANT_BS:
            begin
                if (in_byte == jsu_pkg::CH_BSLASH)
                    phase_next = jsu_pkg::PH_WANT_U;
                else
                    finished = 1'b1;
            end
            jsu_pkg::PH_WANT_U:
            begin
                if (in_byte == jsu_pkg::CH_LOW_U)
                begin
                    phase_next = jsu_pkg::PH_HEX_B;
                    cnt_next   = '0;
                    acc_next   = '0;
                end
                else
                    finished = 1'b1;
            end
            jsu_pkg::PH_IGNORE:
            begin
            end
        endcase

        // UTF-8 encode
        if (emit_cp)
        begin
            priority if (cp[20:7] == '0)
            begin
                nb    = 3'd1;
                ub[0] = cp[7:0];
            end
            else if (cp[20:11] == '0)
            begin
                nb    = 3'd2;
                ub[0] = {3'b110, cp[10:6]};
                ub[1] = {2'b10, cp[5:0]};
            end
            else if (cp[20:16] == '0)
            begin
                nb    = 3'd3;
                ub[0] = {4'b1110, cp[15:12]};
                ub[1] = {2'b10, cp[11:6]};
                ub[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                nb    = 3'd4;
                ub[0] = {5'b11110, cp[20:18]};
                ub[1] = {2'b10, cp[17:12]};
                ub[2] = {2'b10, cp[11:6]};
                ub[3] = {2'b10, cp[5:0]};
            end
        end

        if (phase_reg == jsu_pkg::PH_IGNORE)
        begin
            if (in_last) phase_next = jsu_pkg::PH_OPEN;
        end
        else if (finished)
        begin
            phase_next = in_last ? jsu_pkg::PH_OPEN : jsu_pkg::PH_IGNORE;
            tail_en    = 1'b1;
        end
        else if (in_last)
        begin
            phase_next = jsu_pkg::PH_OPEN;
            tail_en    = 1'b1;
        end

        for (int i = 0; i < jsu_pkg::MaxResults; i++)
        begin
            if (3'(i) < nb)
            begin
                bundle.slot[i].data   = ub[i % 4];
                bundle.slot[i].status = jsu_pkg::ST_BYTE;
            end
            else if (3'(i) == nb && tail_en)
            begin
                bundle.slot[i].data   = '0;
                bundle.slot[i].status = closed ? jsu_pkg::ST_CLOSE : jsu_pkg::ST_ERR;
            end
            else
            begin
                bundle.slot[i].data   = '0;
                bundle.slot[i].status = jsu_pkg::ST_BYTE;
            end
        end
        bundle.cnt = nb + {2'b00, tail_en};
    end

endmodule

// ===== hw/rtl/jsu_emit.sv =====
// Result buffer: holds one bundle and hands its words out one per cycle while m_tready is high.
module jsu_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  jsu_pkg::bundle_t bundle,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast    // run_last
);

    jsu_pkg::entry_t [jsu_pkg::MaxResults-1:0] slot_reg, slot_next;
    logic [jsu_pkg::CntW-1:0]                  cnt_reg, cnt_next;
    logic                                      take;

    assign take     = (cnt_reg != '0) && m_tready;
    assign free     = (cnt_reg == '0) || (cnt_reg == jsu_pkg::CntW'(1) && m_tready);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = slot_reg[0].data;
    assign m_tuser  = slot_reg[0].status;
    assign m_tlast  = (cnt_reg == jsu_pkg::CntW'(1));

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            slot_next = bundle.slot;
            cnt_next  = bundle.cnt;
        end
        else if (take)
        begin
            for (int i = 0; i < jsu_pkg::MaxResults - 1; i++)
                slot_next[i] = slot_reg[i+1];
            slot_next[jsu_pkg::MaxResults-1] = '0;
            cnt_next = cnt_reg - jsu_pkg::CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= jsu_pkg::CntW'(jsu_pkg::MaxResults))
        else $error("result count out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("bundle loaded over undelivered words");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (cnt_reg == $past(cnt_reg)))
        else $error("word count moved during stall");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != jsu_pkg::ST_BYTE) |-> m_tlast)
        else $error("close or error word not last of its run");

endmodule

// ===== hw/rtl/json_string_unescape_core.sv =====
// Top level of the JSON string unescaper: input register, decoder, result buffer.
//
// Takes one raw byte of a quoted JSON string per word and returns decoded UTF-8
// bytes, a close word or an error word (status in m_tuser, m_tlast on the final
// word caused by each input byte). An input byte is taken every cycle when it
// causes at most one result word and m_tready is high; a byte that causes more
// words (a \u escape decoding to 2..4 UTF-8 bytes, or a byte followed by an
// early-end error) holds the input until its last word is taken, as the result
// buffer delivers one word per cycle while m_tready is high.
module json_string_unescape_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [1:0] status
    output logic       m_tlast     // run_last
);

    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             advance;
    logic             load;
    logic             free;
    jsu_pkg::bundle_t bundle;

    assign advance  = in_vld_reg && (free || bundle.cnt == '0);
    assign load     = advance && (bundle.cnt != '0);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .advance (advance),
        .bundle  (bundle)
    );

    jsu_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .bundle   (bundle),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== verif/tb_json_string_unescape_core.sv =====
// Self-checking testbench for json_string_unescape_core: directed table, then random JSON strings.
`timescale 1ns / 100ps

module tb_json_string_unescape_core;

    localparam int IdleLimit  = 1000;
    localparam int ItemTarget = 430;

    typedef struct packed {
        logic [7:0]       data;
        jsu_pkg::status_t status;
        logic             last;
    } word_t;

    typedef struct packed {
        logic [7:0]       b;
        logic             eot;
        logic             typed;
        jsu_pkg::status_t st;
        logic [7:0]       ob;
    } row_t;

    // typed rows carry a single expected word
    localparam row_t DIR_TAB [0:23] = '{
        '{8'h41,              1'b0, 1'b1, jsu_pkg::ST_ERR,   8'h00},  // no opening quote
        '{8'h00,              1'b1, 1'b0, jsu_pkg::ST_BYTE,  8'h00},  // ignored, ends text
        '{jsu_pkg::CH_QUOTE,  1'b1, 1'b1, jsu_pkg::ST_ERR,   8'h00},  // ends on opening quote
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{jsu_pkg::CH_SPACE,  1'b0, 1'b1, jsu_pkg::ST_BYTE,  jsu_pkg::CH_SPACE},
        '{8'hff,              1'b0, 1'b1, jsu_pkg::ST_BYTE,  8'hff},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},  // surrogate pair
        '{jsu_pkg::CH_LOW_U,  1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h44,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h38,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h33,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h44,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{jsu_pkg::CH_LOW_U,  1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h64,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h46,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h30,              1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{jsu_pkg::CH_BSLASH, 1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{jsu_pkg::CH_SLASH,  1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{8'h1f,              1'b0, 1'b1, jsu_pkg::ST_ERR,   8'h00},  // raw control byte
        '{jsu_pkg::CH_BSLASH, 1'b1, 1'b0, jsu_pkg::ST_BYTE,  8'h00},  // ignored, ends text
        '{jsu_pkg::CH_QUOTE,  1'b0, 1'b0, jsu_pkg::ST_BYTE,  8'h00},
        '{jsu_pkg::CH_QUOTE,  1'b1, 1'b1, jsu_pkg::ST_CLOSE, 8'h00}   // close on last byte
    };

    localparam logic [7:0] ESC_CHARS [0:7] = '{
        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_LOW_B,
        jsu_pkg::CH_LOW_F, jsu_pkg::CH_LOW_N, jsu_pkg::CH_LOW_R, jsu_pkg::CH_LOW_T
    };

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    json_string_unescape_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // decoder state mirror
    jsu_pkg::phase_t ph;
    logic [1:0]      hex_cnt;
    logic [15:0]     code_acc;
    logic [9:0]      hi_bits;

    word_t      step_words[$];
    word_t      pending_words[$];
    logic [7:0] text_q[$];
    int         fails = 0;
    int         idle_cycles;
    int         sent_items;
    bit         quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [4:0] hex_nib(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66)
            return {1'b0, 4'(b - 8'h61 + 8'd10)};
        if (b >= 8'h41 && b <= 8'h46)
            return {1'b0, 4'(b - 8'h41 + 8'd10)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void emit(input logic [7:0] data, input jsu_pkg::status_t st);
        word_t w;
        w.data   = data;
        w.status = st;
        w.last   = 1'b0;
        step_words.insert(step_words.size(), w);
    endfunction

    function automatic void emit_utf8(input logic [20:0] cp);
        if (cp <= 21'h7f)
        begin
            emit(cp[7:0], jsu_pkg::ST_BYTE);
        end
        else if (cp <= 21'h7ff)
        begin
            emit({3'b110, cp[10:6]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
        end
        else if (cp <= 21'hffff)
        begin
            emit({4'b1110, cp[15:12]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
        end
        else
        begin
            emit({5'b11110, cp[20:18]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[17:12]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[11:6]}, jsu_pkg::ST_BYTE);
            emit({2'b10, cp[5:0]}, jsu_pkg::ST_BYTE);
        end
    endfunction

    // advance the decoder mirror by one input byte; words land in step_words
    function automatic void decode_step(input logic [7:0] b, input bit eot);
        logic [4:0] nib;
        bit         done;
        done = 1'b0;
        step_words.delete();
        unique case (ph)
            jsu_pkg::PH_OPEN:
                if (b == jsu_pkg::CH_QUOTE)
                begin
                    ph       = jsu_pkg::PH_BODY;
                    hex_cnt  = '0;
                    code_acc = '0;
                    hi_bits  = '0;
                end
                else
                begin
                    emit(8'h00, jsu_pkg::ST_ERR);
                    done = 1'b1;
                end
            jsu_pkg::PH_BODY:
                if (b == jsu_pkg::CH_QUOTE)
                begin
                    emit(8'h00, jsu_pkg::ST_CLOSE);
                    done = 1'b1;
                end
                else if (b < jsu_pkg::CH_SPACE)
                begin
                    emit(8'h00, jsu_pkg::ST_ERR);
                    done = 1'b1;
                end
                else if (b == jsu_pkg::CH_BSLASH)
                begin
                    ph = jsu_pkg::PH_ESC;
                end
                else
                begin
                    emit(b, jsu_pkg::ST_BYTE);
                end
            jsu_pkg::PH_ESC:
            begin
                ph = jsu_pkg::PH_BODY;
                unique case (b)
                    jsu_pkg::CH_QUOTE,
                    jsu_pkg::CH_BSLASH,
                    jsu_pkg::CH_SLASH: emit(b, jsu_pkg::ST_BYTE);
                    jsu_pkg::CH_LOW_B: emit(jsu_pkg::CH_BS, jsu_pkg::ST_BYTE);
                    jsu_pkg::CH_LOW_F: emit(jsu_pkg::CH_FF, jsu_pkg::ST_BYTE);
                    jsu_pkg::CH_LOW_N: emit(jsu_pkg::CH_LF, jsu_pkg::ST_BYTE);
                    jsu_pkg::CH_LOW_R: emit(jsu_pkg::CH_CR, jsu_pkg::ST_BYTE);
                    jsu_pkg::CH_LOW_T: emit(jsu_pkg::CH_TAB, jsu_pkg::ST_BYTE);
                    jsu_pkg::CH_LOW_U:
                    begin
                        ph       = jsu_pkg::PH_HEX_A;
                        hex_cnt  = '0;
                        code_acc = '0;
                    end
                    default:
                    begin
                        emit(8'h00, jsu_pkg::ST_ERR);
                        done = 1'b1;
                    end
                endcase
            end
            jsu_pkg::PH_HEX_A,
            jsu_pkg::PH_HEX_B:
            begin
                nib = hex_nib(b);
                if (nib[4])
                begin
                    emit(8'h00, jsu_pkg::ST_ERR);
                    done = 1'b1;
                end
                else
                begin
                    code_acc = {code_acc[11:0], nib[3:0]};
                    if (hex_cnt != 2'd3)
                    begin
                        hex_cnt = hex_cnt + 2'd1;
                    end
                    else
                    begin
                        hex_cnt = '0;
                        if (ph == jsu_pkg::PH_HEX_A)
                        begin
                            if (code_acc[15:10] == jsu_pkg::HI_SURR_TAG)
                            begin
                                hi_bits = code_acc[9:0];
                                ph      = jsu_pkg::PH_WANT_BS;
                            end
                            else if (code_acc[15:10] == jsu_pkg::LO_SURR_TAG)
                            begin
                                emit(8'h00, jsu_pkg::ST_ERR);
                                done = 1'b1;
                            end
                            else
                            begin
                                emit_utf8({5'd0, code_acc});
                                ph = jsu_pkg::PH_BODY;
                            end
                        end
                        else if (code_acc[15:10] != jsu_pkg::LO_SURR_TAG)
                        begin
                            emit(8'h00, jsu_pkg::ST_ERR);
                            done = 1'b1;
                        end
                        else
                        begin
                            emit_utf8(21'h10000 + {1'b0, hi_bits, code_acc[9:0]});
                            ph = jsu_pkg::PH_BODY;
                        end
                    end
                end
            end
            jsu_pkg::PH_WANT_BS:
                if (b == jsu_pkg::CH_BSLASH)
                begin
                    ph = jsu_pkg::PH_WANT_U;
                end
                else
                begin
                    emit(8'h00, jsu_pkg::ST_ERR);
                    done = 1'b1;
                end
            jsu_pkg::PH_WANT_U:
                if (b == jsu_pkg::CH_LOW_U)
                begin
                    ph       = jsu_pkg::PH_HEX_B;
                    hex_cnt  = '0;
                    code_acc = '0;
                end
                else
                begin
                    emit(8'h00, jsu_pkg::ST_ERR);
                    done = 1'b1;
                end
            default:
            begin
                if (eot)
                    ph = jsu_pkg::PH_OPEN;
                return;
            end
        endcase
        if (done)
        begin
            ph = eot ? jsu_pkg::PH_OPEN : jsu_pkg::PH_IGNORE;
        end
        else if (eot)
        begin
            emit(8'h00, jsu_pkg::ST_ERR);
            ph = jsu_pkg::PH_OPEN;
        end
        if (step_words.size() > 0)
            step_words[step_words.size()-1].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // called at a falling edge with nothing driven yet in that step
    task automatic send_byte(input logic [7:0] b, input bit eot, input bit typed,
                             input jsu_pkg::status_t t_st, input logic [7:0] t_byte);
        int    gap;
        word_t w;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        sent_items++;
        decode_step(b, eot);
        if (typed)
        begin
            w.data   = t_byte;
            w.status = t_st;
            w.last   = 1'b1;
            pending_words.insert(pending_words.size(), w);
        end
        else
            foreach (step_words[i])
                pending_words.insert(pending_words.size(), step_words[i]);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_words();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_words.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic add_hex4(input logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            add_byte(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    task automatic add_token();
        int          r;
        logic [7:0]  b;
        logic [4:0]  nib;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            do
                b = 8'($urandom_range(32, 255));
            while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
            add_byte(b);
        end
        else if (r < 58)
        begin
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(ESC_CHARS[$urandom_range(0, 7)]);
        end
        else if (r < 79)
        begin
            if (r < 66)
                v = 16'($urandom_range(0, 'h7f));
            else if (r < 72)
                v = 16'($urandom_range('h80, 'h7ff));
            else
                do
                    v = 16'($urandom_range('h800, 'hffff));
                while (v[15:11] == 5'b11011);
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(jsu_pkg::CH_LOW_U);
            add_hex4(v);
        end
        else if (r < 94)
        begin
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(jsu_pkg::CH_LOW_U);
            add_hex4(16'($urandom_range('hd800, 'hdbff)));
            add_byte(jsu_pkg::CH_BSLASH);
            add_byte(jsu_pkg::CH_LOW_U);
            add_hex4(16'($urandom_range('hdc00, 'hdfff)));
        end
        else
        begin
            unique case ($urandom_range(0, 4))
                0: add_byte(8'($urandom_range(0, 31)));
                1:
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                                     jsu_pkg::CH_LOW_B, jsu_pkg::CH_LOW_F, jsu_pkg::CH_LOW_N,
                                     jsu_pkg::CH_LOW_R, jsu_pkg::CH_LOW_T, jsu_pkg::CH_LOW_U});
                    add_byte(jsu_pkg::CH_BSLASH);
                    add_byte(b);
                end
                2:
                begin
                    add_byte(jsu_pkg::CH_BSLASH);
                    add_byte(jsu_pkg::CH_LOW_U);
                    repeat ($urandom_range(0, 3))
                        add_byte(hex_char(4'($urandom_range(0, 15)),
                                          1'($urandom_range(0, 1))));
                    do
                    begin
                        b   = 8'($urandom_range(0, 255));
                        nib = hex_nib(b);
                    end
                    while (!nib[4]);
                    add_byte(b);
                end
                3:
                begin
                    add_byte(jsu_pkg::CH_BSLASH);
                    add_byte(jsu_pkg::CH_LOW_U);
                    add_hex4(16'($urandom_range('hdc00, 'hdfff)));
                end
                default:
                begin
                    // high surrogate, then a broken follow-up
                    add_byte(jsu_pkg::CH_BSLASH);
                    add_byte(jsu_pkg::CH_LOW_U);
                    add_hex4(16'($urandom_range('hd800, 'hdbff)));
                    unique case ($urandom_range(0, 2))
                        0:
                        begin
                            do
                                b = 8'($urandom_range(0, 255));
                            while (b == jsu_pkg::CH_BSLASH);
                            add_byte(b);
                        end
                        1:
                        begin
                            do
                                b = 8'($urandom_range(0, 255));
                            while (b == jsu_pkg::CH_LOW_U);
                            add_byte(jsu_pkg::CH_BSLASH);
                            add_byte(b);
                        end
                        default:
                        begin
                            do
                                v = 16'($urandom_range(0, 'hffff));
                            while (v[15:10] == jsu_pkg::LO_SURR_TAG);
                            add_byte(jsu_pkg::CH_BSLASH);
                            add_byte(jsu_pkg::CH_LOW_U);
                            add_hex4(v);
                        end
                    endcase
                end
            endcase
        end
    endtask

    // output sink with random backpressure
    initial
    begin
        int hold;
        int stall;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    hold = stall - 1;
                end
                else
                begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(0, 4);
                end
            end
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        word_t want;
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit)
            begin
                $display("json_string_unescape_core: mismatch");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("unexpected word: out_byte %02h status %0d run_last %0b",
                           m_tdata, m_tuser, m_tlast);
                    fails++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_tdata);
                        fails++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fails++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("run_last: expected %0b, got %0b", want.last, m_tlast);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin
        int         n_tok;
        int         r;
        logic [7:0] first_b;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        sent_items = 0;
        quiet      = 1'b0;
        ph         = jsu_pkg::PH_OPEN;
        hex_cnt    = '0;
        code_acc   = '0;
        hi_bits    = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 24; i++)
            send_byte(DIR_TAB[i].b, DIR_TAB[i].eot, DIR_TAB[i].typed,
                      DIR_TAB[i].st, DIR_TAB[i].ob);
        drain_words();

        while (sent_items < ItemTarget)
        begin
            text_q.delete();
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                // missing opening quote
                do
                    first_b = 8'($urandom_range(0, 255));
                while (first_b == jsu_pkg::CH_QUOTE);
                add_byte(first_b);
            end
            else
            begin
                add_byte(jsu_pkg::CH_QUOTE);
                n_tok = $urandom_range(0, 8);
                repeat (n_tok) add_token();
                if ($urandom_range(0, 99) < 80)
                    add_byte(jsu_pkg::CH_QUOTE);
            end
            // random trailing bytes, after the close or error when there is one
            repeat ($urandom_range(0, 2))
                add_byte(8'($urandom_range(0, 255)));
            quiet = ($urandom_range(0, 7) == 0);
            foreach (text_q[i])
                send_byte(text_q[i], i == text_q.size() - 1, 1'b0, jsu_pkg::ST_BYTE, 8'h00);
            if ($urandom_range(0, 19) == 0)
                drain_words();
        end

        quiet = 1'b0;
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fails == 0)
            $display("json_string_unescape_core: match");
        else
            $display("json_string_unescape_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/jsu_emit.sv
hw/rtl/json_string_unescape_core.sv
verif/tb_json_string_unescape_core.sv
